FILE: src/triangle_envelope_helix_point_gen_top_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef TRIANGLE_ENVELOPE_HELIX_POINT_GEN_TOP_DEFINES_SVH
`define TRIANGLE_ENVELOPE_HELIX_POINT_GEN_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define TEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define TEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/tep_pkg.sv
package tep_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W = 34;
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	localparam logic [7:0] REG_BASE_COUNT = 8'd0;
	localparam logic [7:0] REG_CURLS = 8'd1;

endpackage

FILE: src/triangle_envelope_helix_point_gen_top.sv
// Spiral spire point generator for a vector display.
// Requests enter on the s_axis channel: tdata holds sample_index in the low
// half and fidelity (unsigned Q4.12) in the high half. Each request yields one
// point on the m_axis channel: tdata holds pos_x, pos_y and pos_z (Q1.15),
// tuser holds the in_range flag.
// Registers base_count and curls are written through the cfg channel, which
// is always ready; write them only while no request is in flight.
// Throughput is one request per clock while the receiver does not stall the
// output. The position comes from a bit-per-stage divider and the phase goes
// through the 30 stage CORDIC rotator.
// The whole pipeline advances whenever the output register is empty or being
// taken, so a stalled receiver freezes every stage and s_axis_tready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits and loads base_count = 300, curls = 5.
// SINE_TABLE_DEPTH must be a power of two.
`include "triangle_envelope_helix_point_gen_top_defines.svh"

module triangle_envelope_helix_point_gen_top #(
	parameter int FRAC_BITS = 15,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample_index, fidelity
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // pos_x, pos_y, pos_z
	output logic [0:0]  m_axis_tuser   // in_range
);

	localparam int F = FRAC_BITS;
	localparam int VW = F + 1;
	localparam int NW = F + 17;
	localparam int LD = $clog2(SINE_TABLE_DEPTH);
	localparam int NS = tep_pkg::CORDIC_STEPS;
	localparam int CW = tep_pkg::CORDIC_W;
	localparam int PW = 2 * VW + 1;
	localparam logic [VW-1:0] ONE = VW'(1) << F;
	localparam logic [VW-1:0] HALF = VW'(1) << (F - 1);
	localparam logic signed [CW-1:0] QHI = CW'((64'sd1 <<< F) - 1);
	localparam logic signed [CW-1:0] QLO = CW'(-(64'sd1 <<< F));
	localparam logic signed [PW-1:0] PHI = PW'((64'sd1 <<< F) - 1);
	localparam logic signed [PW-1:0] PLO = PW'(-(64'sd1 <<< F));

	logic [15:0] base_count_q;
	logic [7:0]  curls_q;
	logic        en;

	assign cfg_ready = 1'b1;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_count_q <= 16'd300;
			curls_q <= 8'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				tep_pkg::REG_BASE_COUNT: base_count_q <= cfg_data;
				tep_pkg::REG_CURLS: curls_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1: base count times fidelity.
	logic        vld_s1;
	logic [15:0] idx_s1;
	logic [31:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			idx_s1 <= s_axis_tdata[15:0];
			prod_s1 <= 32'(base_count_q) * 32'(s_axis_tdata[31:16]);
		end
	end

	// Stage 2: count, divisor and numerator, loaded into the divider head.
	logic [32:0] cnt_sum;
	logic [20:0] cnt_w;
	logic [15:0] cnt;
	logic        cnt_ok;
	logic [15:0] dvs;

	assign cnt_sum = {1'b0, prod_s1} + 33'd2048;
	assign cnt_w = cnt_sum[32:12];
	assign cnt = (|cnt_w[20:16]) ? 16'hFFFF : cnt_w[15:0];
	assign cnt_ok = cnt >= 16'd2;
	assign dvs = cnt_ok ? cnt - 16'd1 : 16'd1;

	logic          dv_vld_s3 [NW+1];
	logic [15:0]   dv_rem_s3 [NW+1];
	logic [NW-1:0] dv_num_s3 [NW+1];
	logic [NW-1:0] dv_quo_s3 [NW+1];
	logic [15:0]   dv_den_s3 [NW+1];
	logic          dv_ok_s3  [NW+1];
	logic          dv_rng_s3 [NW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s3[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s3[0] <= vld_s1;
			dv_rem_s3[0] <= '0;
			dv_num_s3[0] <= (NW'(idx_s1) << F) + NW'(dvs >> 1);
			dv_quo_s3[0] <= '0;
			dv_den_s3[0] <= dvs;
			dv_ok_s3[0] <= cnt_ok;
			dv_rng_s3[0] <= idx_s1 < cnt;
		end
	end

	// Restoring divider, one quotient bit per stage.
	for (genvar j = 0; j < NW; j++) begin : g_div
		logic [16:0] trial;
		logic        ge;

		assign trial = {dv_rem_s3[j], dv_num_s3[j][NW-1]};
		assign ge = trial >= {1'b0, dv_den_s3[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s3[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s3[j+1] <= dv_vld_s3[j];
				dv_rem_s3[j+1] <= ge ? 16'(trial - {1'b0, dv_den_s3[j]}) : trial[15:0];
				dv_num_s3[j+1] <= dv_num_s3[j] << 1;
				dv_quo_s3[j+1] <= {dv_quo_s3[j][NW-2:0], ge};
				dv_den_s3[j+1] <= dv_den_s3[j];
				dv_ok_s3[j+1] <= dv_ok_s3[j];
				dv_rng_s3[j+1] <= dv_rng_s3[j];
			end
		end
	end

	// Stage 4: position, width and phase.
	logic [VW-1:0] v_c;
	logic [VW:0]   wd_c;
	logic [VW+7:0] ph_c;

	assign v_c = !dv_ok_s3[NW] ? '0 :
		(dv_quo_s3[NW] > NW'(ONE)) ? ONE : dv_quo_s3[NW][VW-1:0];
	assign wd_c = (v_c <= HALF) ? {v_c, 1'b0} : {ONE, 1'b0} - {v_c, 1'b0};
	assign ph_c = (VW+8)'(v_c) * (VW+8)'(curls_q);

	logic          vld_s4;
	logic [VW-1:0] v_s4;
	logic [VW-1:0] wd_s4;
	logic [F-1:0]  p_s4;
	logic          rng_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= dv_vld_s3[NW];
			v_s4 <= v_c;
			wd_s4 <= wd_c[VW-1:0];
			p_s4 <= ph_c[F-1:0];
			rng_s4 <= dv_rng_s3[NW];
		end
	end

	// Stage 5: table slot, angle, quadrant reduction, CORDIC head.
	logic [F+LD:0]        ksum;
	logic [LD:0]          k_c;
	logic [LD-1:0]        kk_c;
	logic [31:0]          ang_c;
	logic [31:0]          a2_c;
	logic signed [32:0]   z0_c;

	assign ksum = ((F+LD+1)'(p_s4) << LD) + ((F+LD+1)'(1) << (F - 1));
	assign k_c = ksum[F+LD:F];
	assign kk_c = k_c[LD] ? '0 : k_c[LD-1:0];
	assign ang_c = 32'(kk_c) << (32 - LD);
	assign a2_c = ang_c + 32'h2000_0000;
	assign z0_c = $signed({3'b000, a2_c[29:0]}) - 33'sh0_2000_0000;

	logic                 cr_vld_s5 [NS+1];
	logic signed [CW-1:0] cr_x_s5   [NS+1];
	logic signed [CW-1:0] cr_y_s5   [NS+1];
	logic signed [32:0]   cr_z_s5   [NS+1];
	logic [1:0]           cr_qd_s5  [NS+1];
	logic [VW-1:0]        cr_v_s5   [NS+1];
	logic [VW-1:0]        cr_wd_s5  [NS+1];
	logic                 cr_rng_s5 [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_vld_s5[0] <= 1'b0;
		end else if (en) begin
			cr_vld_s5[0] <= vld_s4;
			cr_x_s5[0] <= $signed(CW'(tep_pkg::CORDIC_GAIN));
			cr_y_s5[0] <= '0;
			cr_z_s5[0] <= z0_c;
			cr_qd_s5[0] <= a2_c[31:30];
			cr_v_s5[0] <= v_s4;
			cr_wd_s5[0] <= wd_s4;
			cr_rng_s5[0] <= rng_s4;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [32:0]   at;

		assign dx = cr_y_s5[i] >>> i;
		assign dy = cr_x_s5[i] >>> i;
		assign at = $signed({1'b0, tep_pkg::ATAN_TURNS[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_vld_s5[i+1] <= 1'b0;
			end else if (en) begin
				cr_vld_s5[i+1] <= cr_vld_s5[i];
				if (!cr_z_s5[i][32]) begin
					cr_x_s5[i+1] <= cr_x_s5[i] - dx;
					cr_y_s5[i+1] <= cr_y_s5[i] + dy;
					cr_z_s5[i+1] <= cr_z_s5[i] - at;
				end else begin
					cr_x_s5[i+1] <= cr_x_s5[i] + dx;
					cr_y_s5[i+1] <= cr_y_s5[i] - dy;
					cr_z_s5[i+1] <= cr_z_s5[i] + at;
				end
				cr_qd_s5[i+1] <= cr_qd_s5[i];
				cr_v_s5[i+1] <= cr_v_s5[i];
				cr_wd_s5[i+1] <= cr_wd_s5[i];
				cr_rng_s5[i+1] <= cr_rng_s5[i];
			end
		end
	end

	// Stage 6: quadrant restore, round and clamp sine and cosine.
	logic signed [CW-1:0] cx;
	logic signed [CW-1:0] cy;
	logic signed [CW-1:0] rc;
	logic signed [CW-1:0] rs;
	logic signed [CW-1:0] cc;
	logic signed [CW-1:0] cs;

	always_comb begin
		cx = cr_x_s5[NS];
		cy = cr_y_s5[NS];
		case (cr_qd_s5[NS])
			2'd1: begin
				rc = -cy;
				rs = cx;
			end
			2'd2: begin
				rc = -cx;
				rs = -cy;
			end
			2'd3: begin
				rc = cy;
				rs = -cx;
			end
			default: begin
				rc = cx;
				rs = cy;
			end
		endcase
		cc = (rc + (CW'(1) <<< (29 - F))) >>> (30 - F);
		cs = (rs + (CW'(1) <<< (29 - F))) >>> (30 - F);
		if (cc > QHI) cc = QHI;
		else if (cc < QLO) cc = QLO;
		if (cs > QHI) cs = QHI;
		else if (cs < QLO) cs = QLO;
	end

	logic                 vld_s6;
	logic signed [VW-1:0] sn_s6;
	logic signed [VW-1:0] cs_s6;
	logic [VW-1:0]        v_s6;
	logic [VW-1:0]        wd_s6;
	logic                 rng_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= cr_vld_s5[NS];
			sn_s6 <= cs[VW-1:0];
			cs_s6 <= cc[VW-1:0];
			v_s6 <= cr_v_s5[NS];
			wd_s6 <= cr_wd_s5[NS];
			rng_s6 <= cr_rng_s5[NS];
		end
	end

	// Stage 7: scale by the width.
	logic                 vld_s7;
	logic signed [PW-1:0] mx_s7;
	logic signed [PW-1:0] mz_s7;
	logic [VW-1:0]        v_s7;
	logic                 rng_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
			mx_s7 <= PW'(sn_s6) * $signed(PW'({1'b0, wd_s6}));
			mz_s7 <= PW'(cs_s6) * $signed(PW'({1'b0, wd_s6}));
			v_s7 <= v_s6;
			rng_s7 <= rng_s6;
		end
	end

	// Stage 8: round, clamp, output register.
	logic signed [PW-1:0] rx;
	logic signed [PW-1:0] rz;

	always_comb begin
		rx = (mx_s7 + (PW'(1) <<< (F - 1))) >>> F;
		rz = (mz_s7 + (PW'(1) <<< (F - 1))) >>> F;
		if (rx > PHI) rx = PHI;
		else if (rx < PLO) rx = PLO;
		if (rz > PHI) rz = PHI;
		else if (rz < PLO) rz = PLO;
	end

	logic        vld_s8;
	logic [15:0] px_s8;
	logic [15:0] py_s8;
	logic [15:0] pz_s8;
	logic        rng_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
			px_s8 <= 16'(rx);
			py_s8 <= 16'(v_s7);
			pz_s8 <= 16'(rz);
			rng_s8 <= rng_s7;
		end
	end

	assign m_axis_tvalid = vld_s8;
	assign m_axis_tdata = {pz_s8, py_s8, px_s8};
	assign m_axis_tuser = rng_s8;

	`TEP_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_s1,
		"accepted request did not enter stage one")
	`TEP_ASSERT_NOW(a_width_bound, vld_s4, wd_s4 <= ONE && v_s4 <= ONE,
		"position or width beyond one")
	`TEP_ASSERT_NOW(a_short_count_zero, dv_vld_s3[NW] && !dv_ok_s3[NW], v_c == '0,
		"short count gave a nonzero position")
	`TEP_ASSERT_NEXT(a_stall_freeze, m_axis_tvalid && !m_axis_tready,
		vld_s7 == $past(vld_s7) && rng_s8 == $past(rng_s8),
		"pipeline moved during a stall")

endmodule
